FILE: rtl/kmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmi_pkg: keyframe motion interpolator shared definitions
// Table sizes, field widths, item codes, payload structs and address helpers.
// ----------------------------------------------------------------------------
package kmi_pkg;

  // Table dimensions
  localparam int MOTIONS  = 16;
  localparam int KEYS     = 16;
  localparam int PARTS    = 16;
  localparam int CHANNELS = 6;

  // Field widths
  localparam int KIND_W = 3;
  localparam int MIDX_W = 4;
  localparam int KIDX_W = 4;
  localparam int PIDX_W = 4;
  localparam int CH_W   = 3;
  localparam int VAL_W  = 32;
  localparam int FRM_W  = 16;
  localparam int KC_W   = 5;
  localparam int PIU_W  = 5;

  // Memory geometry
  localparam int KV_DEPTH = MOTIONS * KEYS * PARTS * CHANNELS;
  localparam int KV_AW    = $clog2(KV_DEPTH);
  localparam int KF_DEPTH = MOTIONS * KEYS;
  localparam int KF_AW    = $clog2(KF_DEPTH);
  localparam int PO_DEPTH = PARTS * CHANNELS;
  localparam int PO_AW    = $clog2(PO_DEPTH);

  // Datapath widths
  localparam int PCNT_W = $clog2(PARTS + 1);
  localparam int PROD_W = VAL_W + 1 + FRM_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int DCNT_W = $clog2(PROD_W + 1);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_KEY_VALUE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_KEY_FRMS  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MOTION    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PART      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SET_MOT   = 3'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL      = 1'b1;
  localparam int CFG_DATA_W = 5;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [MIDX_W-1:0]       motion_index;
    logic [KIDX_W-1:0]       key_index;
    logic [PIDX_W-1:0]       part_index;
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] value;
    logic [FRM_W-1:0]        frames;
    logic [KC_W-1:0]         key_count;
    logic                    loop_flag;
    logic                    part_used;
  } in_item_t;

  typedef struct packed {
    logic [PIDX_W-1:0]       part_number;
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] pos_z;
    logic signed [VAL_W-1:0] rot_x;
    logic signed [VAL_W-1:0] rot_y;
    logic signed [VAL_W-1:0] rot_z;
    logic                    last;
  } out_item_t;

  // Flat key value address: motion, key, part, channel
  function automatic logic [KV_AW-1:0] kv_addr(input logic [MIDX_W-1:0] m,
                                                input logic [KIDX_W-1:0] k,
                                                input logic [PIDX_W-1:0] p,
                                                input logic [CH_W-1:0] c);
    kv_addr = KV_AW'(((int'(m) * KEYS + int'(k)) * PARTS + int'(p)) * CHANNELS + int'(c));
  endfunction

  function automatic logic [KF_AW-1:0] kf_addr(input logic [MIDX_W-1:0] m,
                                               input logic [KIDX_W-1:0] k);
    kf_addr = KF_AW'(int'(m) * KEYS + int'(k));
  endfunction

  function automatic logic [PO_AW-1:0] po_addr(input logic [PIDX_W-1:0] p,
                                               input logic [CH_W-1:0] c);
    po_addr = PO_AW'(int'(p) * CHANNELS + int'(c));
  endfunction

endpackage

FILE: rtl/kmi_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmi_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module kmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/kmi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmi_div: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module kmi_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [kmi_pkg::PROD_W-1:0] dividend,
  input  wire logic        [kmi_pkg::FRM_W-1:0]  divisor,
  output logic                                   done,
  output logic signed      [kmi_pkg::PROD_W-1:0] quotient
);

  logic                         busy;
  logic [kmi_pkg::DCNT_W-1:0]   steps;
  logic                         neg;
  logic [kmi_pkg::PROD_W-1:0]   mag;
  logic [kmi_pkg::FRM_W-1:0]    rem;
  logic [kmi_pkg::FRM_W-1:0]    dvs;
  logic [kmi_pkg::FRM_W:0]      trial;
  logic                         qbit;

  // One shift-subtract step
  always_comb begin
    trial = {rem, mag[kmi_pkg::PROD_W-1]};
    qbit  = (trial >= {1'b0, dvs});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= kmi_pkg::DCNT_W'(kmi_pkg::PROD_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == kmi_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[kmi_pkg::PROD_W-1];
      mag <= dividend[kmi_pkg::PROD_W-1] ? kmi_pkg::PROD_W'(-dividend)
                                         : kmi_pkg::PROD_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= qbit ? kmi_pkg::FRM_W'(trial - {1'b0, dvs}) : trial[kmi_pkg::FRM_W-1:0];
      mag <= {mag[kmi_pkg::PROD_W-2:0], qbit};
    end
  end

  assign quotient = neg ? -$signed(mag) : $signed(mag);

endmodule
`default_nettype wire

FILE: rtl/keyframe_motion_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_motion_interpolator: keyframe animation player
// Loads key, motion and part tables and interpolates one pose per used part
// on each tick.
// ----------------------------------------------------------------------------
// Load and set-motion items do not stall the input. A tick keeps the input
// stalled while the sequencer reads the key's frame count, scans every part
// below parts_in_use and, for each used part, works through six channels (two
// key value reads, a multiply, and a 50-step divide in the shared iterative
// divider) and then loads the result, and finally steps the frame and key. A
// result waiting on a stalled output holds the tick at that part. Key values
// and part offsets live in single-port-read RAMs read once per access; there
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
module keyframe_motion_interpolator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire kmi_pkg::in_item_t                 in_item,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output kmi_pkg::out_item_t                     out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [kmi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kmi_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FRM    = 4'd1;
  localparam logic [3:0] S_PART   = 4'd2;
  localparam logic [3:0] S_RD_NOW = 4'd3;
  localparam logic [3:0] S_RD_NXT = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;
  localparam logic [3:0] S_STEP   = 4'd9;

  logic [3:0] state;

  // Configuration and play state
  logic [kmi_pkg::PIU_W-1:0]  parts_in_use;
  logic [kmi_pkg::MIDX_W-1:0] neutral_motion;
  logic [kmi_pkg::MIDX_W-1:0] cur_motion;
  logic [kmi_pkg::KIDX_W-1:0] cur_key;
  logic [kmi_pkg::FRM_W-1:0]  frame_counter;
  logic [kmi_pkg::PARTS-1:0]  used_flags;
  logic [kmi_pkg::KC_W:0]     motion_info [kmi_pkg::MOTIONS];

  // Per-tick registers
  logic [kmi_pkg::KIDX_W-1:0] t_key;
  logic [kmi_pkg::KIDX_W-1:0] t_nkey;
  logic [kmi_pkg::KC_W-1:0]   t_kc;
  logic                       t_loop;
  logic [kmi_pkg::FRM_W-1:0]  frames_eff;
  logic [kmi_pkg::PCNT_W-1:0] limit;
  logic [kmi_pkg::PCNT_W-1:0] part_cnt;
  logic [kmi_pkg::CH_W-1:0]   chan;
  logic signed [kmi_pkg::VAL_W-1:0]  now_val;
  logic signed [kmi_pkg::VAL_W-1:0]  off_val;
  logic signed [kmi_pkg::PROD_W-1:0] prod;
  logic signed [kmi_pkg::VAL_W-1:0]  res [kmi_pkg::CHANNELS];

  // Combinational helpers
  logic                       accept;
  logic [kmi_pkg::KIDX_W-1:0] key_cl;
  logic [kmi_pkg::KC_W-1:0]   kc_raw;
  logic [kmi_pkg::KC_W-1:0]   kc_eff;
  logic [kmi_pkg::KC_W-1:0]   key_inc;
  logic [kmi_pkg::KIDX_W-1:0] nkey;
  logic [kmi_pkg::PIDX_W-1:0] pidx;
  logic                       later_used;
  logic [kmi_pkg::FRM_W:0]    cnt_inc;
  logic [kmi_pkg::KC_W-1:0]   t_key_inc;
  logic signed [kmi_pkg::SUM_W-1:0] sum;
  logic signed [kmi_pkg::VAL_W-1:0] sat;

  // Memories
  logic                        kv_we;
  logic [kmi_pkg::KV_AW-1:0]   kv_waddr;
  logic [kmi_pkg::KV_AW-1:0]   kv_raddr;
  logic [kmi_pkg::VAL_W-1:0]   kv_rdata;
  logic                        kf_we;
  logic [kmi_pkg::FRM_W-1:0]   kf_rdata;
  logic                        po_we;
  logic [kmi_pkg::VAL_W-1:0]   po_rdata;

  // Divider
  logic                              div_start;
  logic                              div_done;
  logic signed [kmi_pkg::PROD_W-1:0] div_q;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign pidx      = part_cnt[kmi_pkg::PIDX_W-1:0];
  assign div_start = (state == S_DSTART);

  // Current key, key count and next key
  always_comb begin
    key_cl  = ({1'b0, cur_key} >= kmi_pkg::KC_W'(kmi_pkg::KEYS))
              ? kmi_pkg::KIDX_W'(kmi_pkg::KEYS - 1) : cur_key;
    kc_raw  = motion_info[cur_motion][kmi_pkg::KC_W-1:0];
    kc_eff  = (kc_raw > kmi_pkg::KC_W'(kmi_pkg::KEYS))
              ? kmi_pkg::KC_W'(kmi_pkg::KEYS) : kc_raw;
    key_inc = {1'b0, key_cl} + 1'b1;
    if (key_inc >= kc_eff) begin
      nkey = motion_info[cur_motion][kmi_pkg::KC_W] ? '0 : key_cl;
    end else begin
      nkey = key_inc[kmi_pkg::KIDX_W-1:0];
    end
  end

  // Any used part after the current one within the limit
  always_comb begin
    later_used = 1'b0;
    for (int i = 0; i < kmi_pkg::PARTS; i++) begin
      if (kmi_pkg::PCNT_W'(i) > part_cnt && kmi_pkg::PCNT_W'(i) < limit && used_flags[i]) begin
        later_used = 1'b1;
      end
    end
  end

  // Memory write enables and addresses
  always_comb begin
    kv_we = accept && in_item.kind == kmi_pkg::KIND_KEY_VALUE
            && int'(in_item.motion_index) < kmi_pkg::MOTIONS
            && int'(in_item.key_index) < kmi_pkg::KEYS
            && int'(in_item.part_index) < kmi_pkg::PARTS
            && int'(in_item.channel) < kmi_pkg::CHANNELS;
    kf_we = accept && in_item.kind == kmi_pkg::KIND_KEY_FRMS
            && int'(in_item.motion_index) < kmi_pkg::MOTIONS
            && int'(in_item.key_index) < kmi_pkg::KEYS;
    po_we = accept && in_item.kind == kmi_pkg::KIND_PART
            && int'(in_item.part_index) < kmi_pkg::PARTS
            && int'(in_item.channel) < kmi_pkg::CHANNELS;
    kv_waddr = kmi_pkg::kv_addr(in_item.motion_index, in_item.key_index,
                                in_item.part_index, in_item.channel);
    kv_raddr = kmi_pkg::kv_addr(cur_motion, (state == S_RD_NXT) ? t_nkey : t_key,
                                pidx, chan);
  end

  kmi_ram #(.WIDTH(kmi_pkg::VAL_W), .DEPTH(kmi_pkg::KV_DEPTH)) u_kv_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (kv_waddr),
    .wdata (in_item.value),
    .raddr (kv_raddr),
    .rdata (kv_rdata)
  );

  kmi_ram #(.WIDTH(kmi_pkg::FRM_W), .DEPTH(kmi_pkg::KF_DEPTH)) u_kf_ram (
    .clk   (clk),
    .we    (kf_we),
    .waddr (kmi_pkg::kf_addr(in_item.motion_index, in_item.key_index)),
    .wdata (in_item.frames),
    .raddr (kmi_pkg::kf_addr(cur_motion, key_cl)),
    .rdata (kf_rdata)
  );

  kmi_ram #(.WIDTH(kmi_pkg::VAL_W), .DEPTH(kmi_pkg::PO_DEPTH)) u_po_ram (
    .clk   (clk),
    .we    (po_we),
    .waddr (kmi_pkg::po_addr(in_item.part_index, in_item.channel)),
    .wdata (in_item.value),
    .raddr (kmi_pkg::po_addr(pidx, chan)),
    .rdata (po_rdata)
  );

  kmi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (frames_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // Final sum and saturation
  always_comb begin
    sum = kmi_pkg::SUM_W'(off_val) + kmi_pkg::SUM_W'(now_val) + kmi_pkg::SUM_W'(div_q);
    if (sum > kmi_pkg::SUM_W'(32'sh7fffffff)) begin
      sat = 32'sh7fffffff;
    end else if (sum < kmi_pkg::SUM_W'(-33'sh80000000)) begin
      sat = -32'sh80000000;
    end else begin
      sat = sum[kmi_pkg::VAL_W-1:0];
    end
    cnt_inc   = {1'b0, frame_counter} + 1'b1;
    t_key_inc = {1'b0, t_key} + 1'b1;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parts_in_use   <= '0;
      neutral_motion <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kmi_pkg::CFG_PARTS_IN_USE: parts_in_use   <= cfg_data;
        kmi_pkg::CFG_NEUTRAL:      neutral_motion <= cfg_data[kmi_pkg::MIDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Motion info table, written by load items only
  always_ff @(posedge clk) begin
    if (accept && in_item.kind == kmi_pkg::KIND_MOTION
        && int'(in_item.motion_index) < kmi_pkg::MOTIONS) begin
      motion_info[in_item.motion_index] <= {in_item.loop_flag, in_item.key_count};
    end
  end

  // Sequencer and play state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cur_motion    <= '0;
      cur_key       <= '0;
      frame_counter <= '0;
      used_flags    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_item.kind)
              kmi_pkg::KIND_TICK: begin
                t_key  <= key_cl;
                t_nkey <= nkey;
                t_kc   <= kc_eff;
                t_loop <= motion_info[cur_motion][kmi_pkg::KC_W];
                limit  <= (parts_in_use > kmi_pkg::PIU_W'(kmi_pkg::PARTS))
                          ? kmi_pkg::PCNT_W'(kmi_pkg::PARTS)
                          : kmi_pkg::PCNT_W'(parts_in_use);
                state  <= S_FRM;
              end
              kmi_pkg::KIND_PART: begin
                if (int'(in_item.part_index) < kmi_pkg::PARTS) begin
                  used_flags[in_item.part_index] <= in_item.part_used;
                end
              end
              kmi_pkg::KIND_SET_MOT: begin
                if (int'(in_item.motion_index) < kmi_pkg::MOTIONS
                    && in_item.motion_index != cur_motion) begin
                  cur_motion    <= in_item.motion_index;
                  cur_key       <= '0;
                  frame_counter <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_FRM: begin
          frames_eff <= (kf_rdata == '0) ? kmi_pkg::FRM_W'(1) : kf_rdata;
          part_cnt   <= '0;
          state      <= S_PART;
        end
        S_PART: begin
          if (part_cnt >= limit) begin
            state <= S_STEP;
          end else if (used_flags[pidx]) begin
            chan  <= '0;
            state <= S_RD_NOW;
          end else begin
            part_cnt <= part_cnt + 1'b1;
          end
        end
        S_RD_NOW: state <= S_RD_NXT;
        S_RD_NXT: begin
          now_val <= kv_rdata;
          off_val <= po_rdata;
          state   <= S_MUL;
        end
        S_MUL: begin
          prod  <= (kmi_pkg::PROD_W'($signed(kv_rdata)) - kmi_pkg::PROD_W'(now_val))
                   * $signed({1'b0, frame_counter});
          state <= S_DSTART;
        end
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            res[chan] <= sat;
            if (int'(chan) == kmi_pkg::CHANNELS - 1) begin
              state <= S_EMIT;
            end else begin
              chan  <= chan + 1'b1;
              state <= S_RD_NOW;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_item.part_number <= pidx;
            out_item.pos_x       <= res[0];
            out_item.pos_y       <= res[1];
            out_item.pos_z       <= res[2];
            out_item.rot_x       <= res[3];
            out_item.rot_y       <= res[4];
            out_item.rot_z       <= res[5];
            out_item.last        <= !later_used;
            part_cnt             <= part_cnt + 1'b1;
            state                <= S_PART;
          end
        end
        S_STEP: begin
          state <= S_IDLE;
          if (cnt_inc >= {1'b0, frames_eff}) begin
            frame_counter <= '0;
            if (t_key_inc >= t_kc) begin
              cur_key <= '0;
              if (!t_loop) begin
                cur_motion <= (int'(neutral_motion) < kmi_pkg::MOTIONS) ? neutral_motion : '0;
              end
            end else begin
              cur_key <= t_key_inc[kmi_pkg::KIDX_W-1:0];
            end
          end else begin
            frame_counter <= cnt_inc[kmi_pkg::FRM_W-1:0];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done outside divide state");

  // After a key step the frame counter stays below the frame count
  a_counter_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |=> (frame_counter < frames_eff))
    else $error("frame counter at or above frame count after step");

  // A result is only loaded for a part inside the tick's limit
  a_emit_in_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (part_cnt < limit && used_flags[pidx]))
    else $error("result for a part outside the limit or unused");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: keyframe motion interpolator testbench
// Preloads a few motions, walks a table of directed items, then sends random
// items in several idle/stall phases. A behavioral model of the player
// predicts every pose, and each output item is compared field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT = 10000000;
  // Keys and parts loaded for every prepared motion
  localparam int PREP_KEYS  = 2;
  localparam int PREP_PARTS = 2;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  kmi_pkg::in_item_t in_item;
  kmi_pkg::out_item_t out_item;
  logic [kmi_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kmi_pkg::CFG_DATA_W-1:0] cfg_data;

  keyframe_motion_interpolator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Player model state
  int          key_val[kmi_pkg::MOTIONS][kmi_pkg::KEYS][kmi_pkg::PARTS][kmi_pkg::CHANNELS];
  logic [15:0] key_frm[kmi_pkg::MOTIONS][kmi_pkg::KEYS];
  logic [5:0]  mot_info[kmi_pkg::MOTIONS];
  int          part_off[kmi_pkg::PARTS][kmi_pkg::CHANNELS];
  bit          part_on[kmi_pkg::PARTS];
  int unsigned cur_mot, cur_key, frame_cnt, parts_cfg, neutral_cfg;

  kmi_pkg::out_item_t pose_q[$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0;
  int unsigned cycles = 0;

  // Motions whose key tables are preloaded; only these are ever played
  int prepared[2] = '{0, 15};

  typedef struct {
    bit                            is_cfg;
    logic [kmi_pkg::CFG_IDX_W-1:0] idx;
    logic [4:0]                    data;
    kmi_pkg::in_item_t             it;
    bit                            has_pose;
    kmi_pkg::out_item_t            pose;
  } row_t;
  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic kmi_pkg::in_item_t mk(logic [2:0] kind, int m, int k, int p, int c,
                                           logic [31:0] v, int f, int kc, bit lp, bit pu);
    kmi_pkg::in_item_t it;
    it.kind = kind; it.motion_index = m; it.key_index = k; it.part_index = p;
    it.channel = c; it.value = v; it.frames = f; it.key_count = kc;
    it.loop_flag = lp; it.part_used = pu;
    return it;
  endfunction

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(400000)) - 200000);
      default: return $urandom;
    endcase
  endfunction

  // Pose interpolation for one tick, then frame/key stepping
  task automatic play_tick();
    int unsigned m, k, kc, nk, fr, lim;
    bit lp;
    longint now, nxt, st, v;
    int ch[kmi_pkg::CHANNELS];
    kmi_pkg::out_item_t r;
    kmi_pkg::out_item_t poses[$];
    m = cur_mot;
    k = cur_key;
    kc = mot_info[m][4:0] > kmi_pkg::KEYS ? kmi_pkg::KEYS : mot_info[m][4:0];
    lp = mot_info[m][5];
    if (k + 1 >= kc) nk = lp ? 0 : k;
    else nk = k + 1;
    fr = key_frm[m][k] == 0 ? 1 : key_frm[m][k];
    lim = parts_cfg > kmi_pkg::PARTS ? kmi_pkg::PARTS : parts_cfg;
    for (int p = 0; p < lim; p++) begin
      if (!part_on[p]) continue;
      for (int c = 0; c < kmi_pkg::CHANNELS; c++) begin
        now = key_val[m][k][p][c];
        nxt = key_val[m][nk][p][c];
        st = ((nxt - now) * longint'(frame_cnt)) / longint'(fr);
        v = longint'(part_off[p][c]) + now + st;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        ch[c] = int'(v);
      end
      r.part_number = p;
      r.pos_x = ch[0]; r.pos_y = ch[1]; r.pos_z = ch[2];
      r.rot_x = ch[3]; r.rot_y = ch[4]; r.rot_z = ch[5];
      r.last = 1'b0;
      poses.push_back(r);
    end
    if (poses.size() > 0) poses[poses.size()-1].last = 1'b1;
    foreach (poses[i]) pose_q.push_back(poses[i]);
    frame_cnt++;
    if (frame_cnt >= fr) begin
      frame_cnt = 0;
      cur_key = k + 1;
      if (cur_key >= kc) begin
        cur_key = 0;
        if (!lp) cur_mot = neutral_cfg < kmi_pkg::MOTIONS ? neutral_cfg : 0;
      end
    end
  endtask

  task automatic apply_item(kmi_pkg::in_item_t it);
    case (it.kind)
      kmi_pkg::KIND_TICK: play_tick();
      kmi_pkg::KIND_KEY_VALUE:
        if (it.channel < kmi_pkg::CHANNELS)
          key_val[it.motion_index][it.key_index][it.part_index][it.channel] = it.value;
      kmi_pkg::KIND_KEY_FRMS: key_frm[it.motion_index][it.key_index] = it.frames;
      kmi_pkg::KIND_MOTION: mot_info[it.motion_index] = {it.loop_flag, it.key_count};
      kmi_pkg::KIND_PART: begin
        part_on[it.part_index] = it.part_used;
        if (it.channel < kmi_pkg::CHANNELS) part_off[it.part_index][it.channel] = it.value;
      end
      kmi_pkg::KIND_SET_MOT:
        if (it.motion_index != cur_mot) begin
          cur_mot = it.motion_index;
          cur_key = 0;
          frame_cnt = 0;
        end
      default: ;
    endcase
  endtask

  task automatic send(kmi_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    apply_item(it);
  endtask

  // Register write, only once the block has drained
  task automatic write_reg(logic [kmi_pkg::CFG_IDX_W-1:0] idx, logic [4:0] data);
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == kmi_pkg::CFG_PARTS_IN_USE) parts_cfg = data;
    else neutral_cfg = data[3:0];
  endtask

  function automatic kmi_pkg::in_item_t rnd_item();
    int m, p;
    m = prepared[$urandom_range(1)];
    p = $urandom_range(3);
    case ($urandom_range(99)) inside
      [0:29]: return mk(kmi_pkg::KIND_TICK, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom);
      [30:59]: begin
        if ($urandom_range(4) == 0) begin
          m = $urandom_range(15);
          p = $urandom_range(15);
        end
        return mk(kmi_pkg::KIND_KEY_VALUE, m, $urandom_range(15), p, $urandom_range(7),
                  rnd_val(), $urandom, $urandom, $urandom, $urandom);
      end
      [60:69]: return mk(kmi_pkg::KIND_KEY_FRMS, $urandom_range(15), $urandom_range(15),
                         $urandom, $urandom, $urandom,
                         ($urandom_range(30) == 0) ? $urandom_range(65535) : $urandom_range(3),
                         $urandom, $urandom, $urandom);
      // key counts stay within the prepared keys
      [70:77]: return mk(kmi_pkg::KIND_MOTION, $urandom_range(15), $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom_range(PREP_KEYS),
                         $urandom, $urandom);
      [78:87]: begin
        // only prepared parts may be marked used
        p = $urandom_range(15);
        return mk(kmi_pkg::KIND_PART, $urandom, $urandom, p, $urandom_range(7), rnd_val(),
                  $urandom, $urandom, $urandom, (p < PREP_PARTS) ? $urandom_range(1) : 0);
      end
      [88:94]: return mk(kmi_pkg::KIND_SET_MOT, m, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
      default: return mk($urandom_range(6, 7), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Output side: random stall, compare each item against the oldest pose
  always @(posedge clk) begin
    kmi_pkg::out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual %p", $time, out_item);
        errors++;
      end else begin
        e = pose_q.pop_front();
        check_field("part_number", e.part_number, out_item.part_number);
        check_field("pos_x", e.pos_x, out_item.pos_x);
        check_field("pos_y", e.pos_y, out_item.pos_y);
        check_field("pos_z", e.pos_z, out_item.pos_z);
        check_field("rot_x", e.rot_x, out_item.rot_x);
        check_field("rot_y", e.rot_y, out_item.rot_y);
        check_field("rot_z", e.rot_z, out_item.rot_z);
        check_field("last", e.last, out_item.last);
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic add_item(kmi_pkg::in_item_t it);
    row_t r;
    r = '{default: '0};
    r.it = it;
    rows.push_back(r);
  endtask

  task automatic add_pose(logic [31:0] x);
    rows[rows.size()-1].has_pose = 1'b1;
    rows[rows.size()-1].pose = '{part_number: 0, pos_x: x, pos_y: 0, pos_z: 0,
                                 rot_x: 0, rot_y: 0, rot_z: 0, last: 1'b1};
  endtask

  initial begin
    int m;
    row_t r;
    in_valid = 1'b0; in_item = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    rst = 1'b1;
    cur_mot = 0; cur_key = 0; frame_cnt = 0; parts_cfg = 0; neutral_cfg = 0;
    foreach (part_on[i]) part_on[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(kmi_pkg::CFG_PARTS_IN_USE, 5'd0);
    write_reg(kmi_pkg::CFG_NEUTRAL, 5'd15);

    // Preload: motion 15 all zero with one non-looping key, others random
    foreach (prepared[i]) begin
      m = prepared[i];
      send(mk(kmi_pkg::KIND_MOTION, m, 0, 0, 0, 0, 0,
              (m == 15) ? 1 : $urandom_range(1, PREP_KEYS),
              (m == 15) ? 0 : $urandom_range(1), 0));
      for (int k = 0; k < PREP_KEYS; k++) begin
        send(mk(kmi_pkg::KIND_KEY_FRMS, m, k, 0, 0, 0, (m == 15) ? 0 : $urandom_range(3),
                0, 0, 0));
        for (int p = 0; p < PREP_PARTS; p++)
          for (int c = 0; c < kmi_pkg::CHANNELS; c++)
            send(mk(kmi_pkg::KIND_KEY_VALUE, m, k, p, c, (m == 15) ? 32'h0 : rnd_val(),
                    0, 0, 0, 0));
      end
    end
    for (int p = 0; p < PREP_PARTS; p++)
      for (int c = 0; c < kmi_pkg::CHANNELS; c++)
        send(mk(kmi_pkg::KIND_PART, 0, 0, p, c, (p == 0) ? 32'h0 : rnd_val(), 0, 0, 0, 0));

    // Directed table
    add_item(mk(kmi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));    // no parts in use
    r = '{default: '0}; r.is_cfg = 1'b1; r.idx = kmi_pkg::CFG_PARTS_IN_USE; r.data = 5'd31;
    rows.push_back(r);                                               // above PARTS
    add_item(mk(kmi_pkg::KIND_SET_MOT, 15, 0, 0, 0, 0, 0, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_PART, 0, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 1));
    add_item(mk(kmi_pkg::KIND_KEY_VALUE, 15, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_pose(32'h7fffffff);                                          // saturates high
    add_item(mk(kmi_pkg::KIND_KEY_VALUE, 15, 0, 0, 0, 32'h80000000, 0, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_PART, 0, 0, 0, 0, 32'h80000000, 0, 0, 0, 1));
    add_item(mk(kmi_pkg::KIND_TICK, 7, 15, 15, 7, 32'hffffffff, 16'hffff, 31, 1, 1));
    add_pose(32'h80000000);                                          // saturates low
    add_item(mk(3'd6, 15, 15, 15, 7, 32'hffffffff, 16'hffff, 31, 1, 1));
    add_item(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_KEY_VALUE, 15, 15, 15, 6, 32'h12345678, 0, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_KEY_VALUE, 15, 15, 15, 7, 32'h12345678, 0, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_PART, 0, 0, 15, 7, 32'hffffffff, 0, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_KEY_FRMS, 15, 0, 0, 0, 0, 16'hffff, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_MOTION, 15, 0, 0, 0, 0, 0, 31, 1, 0)); // key count above KEYS
    add_item(mk(kmi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_SET_MOT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_MOTION, 15, 0, 0, 0, 0, 0, 1, 0, 0));  // back to one key
    add_item(mk(kmi_pkg::KIND_PART, 0, 0, 1, 3, rnd_val(), 0, 0, 0, 1));
    add_item(mk(kmi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_SET_MOT, 0, 0, 0, 0, 0, 0, 0, 0, 0));  // same motion
    add_item(mk(kmi_pkg::KIND_MOTION, 0, 0, 0, 0, 0, 0, 0, 0, 0));   // zero keys
    add_item(mk(kmi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_item(mk(kmi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send(rows[i].it);
        if (rows[i].has_pose) begin
          void'(pose_q.pop_back());
          pose_q.push_back(rows[i].pose);
        end
      end
    end

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 77; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 77; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      write_reg(kmi_pkg::CFG_PARTS_IN_USE,
                (ph == 0) ? 5'd16 : (ph == 3) ? 5'd4 : 5'($urandom_range(31)));
      write_reg(kmi_pkg::CFG_NEUTRAL, (ph == 1) ? 5'd0 : 5'(prepared[$urandom_range(1)]));
      for (int i = 0; i < 40; i++) begin
        if (ph == 2 && i == 20) begin
          in_valid <= 1'b0;
          while (pose_q.size() != 0) @(posedge clk);
        end
        send(rnd_item());
      end
    end
    in_valid <= 1'b0;

    while (pose_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/kmi_pkg.sv
rtl/kmi_ram.sv
rtl/kmi_div.sv
rtl/keyframe_motion_interpolator.sv
tb/tb.sv
